### hdl/nearest_neighbor_frame_scaler_defines.svh
// Assertion macros shared by the scaler checker.
`ifndef NEAREST_NEIGHBOR_FRAME_SCALER_DEFINES_SVH
`define NEAREST_NEIGHBOR_FRAME_SCALER_DEFINES_SVH

// Next-cycle implication, ignored while reset is asserted.
`define NNFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also runs during reset.
`define NNFS_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/nnfs_pkg.sv
// Shared types, widths and defaults of the nearest-neighbor frame scaler.
package nnfs_pkg;

  localparam int SRC_W_BITS    = 10;
  localparam int SRC_H_BITS    = 9;
  localparam int DIM_BITS      = 12;
  localparam int OFFSET_BITS   = 23;
  localparam int FS_BITS       = SRC_W_BITS + SRC_H_BITS;
  localparam int IN_PIX_BITS   = 8;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 12;
  localparam int NUM_CFG       = 5;

  localparam int STORE_DEPTH_DEF  = 131072;
  localparam int MAX_DEST_DIM_DEF = 2048;
  localparam int PIXEL_BITS_DEF   = 8;

  localparam logic [SRC_W_BITS-1:0] SRC_W_RST = SRC_W_BITS'(320);
  localparam logic [SRC_H_BITS-1:0] SRC_H_RST = SRC_H_BITS'(200);
  localparam logic [DIM_BITS-1:0]   DST_W_RST = DIM_BITS'(640);
  localparam logic [DIM_BITS-1:0]   DST_H_RST = DIM_BITS'(400);
  localparam logic [DIM_BITS-1:0]   PITCH_RST = DIM_BITS'(640);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SRC_WIDTH  = 3'd0,
    CFG_SRC_HEIGHT = 3'd1,
    CFG_DST_WIDTH  = 3'd2,
    CFG_DST_HEIGHT = 3'd3,
    CFG_ROW_PITCH  = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_START,
    ST_DIV,
    ST_MUL,
    ST_RUN
  } state_t;

endpackage

### hdl/nnfs_ram.sv
// Generic simple dual-port RAM with registered read.
module nnfs_ram #(
  parameter int WIDTH = nnfs_pkg::PIXEL_BITS_DEF,
  parameter int DEPTH = nnfs_pkg::STORE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/nnfs_div.sv
// Restoring divider, one quotient bit per cycle.
module nnfs_div #(
  parameter int N_BITS = nnfs_pkg::SRC_W_BITS,
  parameter int D_BITS = nnfs_pkg::DIM_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [N_BITS-1:0] dividend,
  input  logic [D_BITS-1:0] divisor,
  output logic [N_BITS-1:0] quotient,
  output logic [D_BITS-1:0] remainder,
  output logic              done
);

  localparam int CNT_W = $clog2(N_BITS + 1);

  logic [N_BITS-1:0] q_r;
  logic [D_BITS-1:0] rem_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [D_BITS:0]   trial;
  logic [D_BITS:0]   diff;
  logic              ge;
  logic [D_BITS-1:0] rem_nxt;

  always_comb begin
    trial   = {rem_r, q_r[N_BITS-1]};
    diff    = trial - {1'b0, divisor};
    ge      = trial >= {1'b0, divisor};
    rem_nxt = ge ? diff[D_BITS-1:0] : trial[D_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      q_r    <= dividend;
      rem_r  <= '0;
      cnt_r  <= '0;
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      // shift in one quotient bit
      q_r   <= {q_r[N_BITS-2:0], ge};
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(N_BITS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  assign quotient  = q_r;
  assign remainder = rem_r;
  assign done      = done_r;

endmodule

### hdl/nearest_neighbor_frame_scaler.sv
// Nearest-neighbor frame scaler: frame store, step setup and address generation.
// Throughput: one word per cycle on the input channel when not stalled, loads
//   and emits alike. An accepted emit word passes the frame store read, then
//   the output register, before its result is valid.
// After reset and after every write to a listed register, the input stalls
//   while the setup and the restoring dividers derive the column and row steps.
// Reset (rst_n low, synchronous) restores default registers and clears counters.
module nearest_neighbor_frame_scaler #(
  parameter int STORE_DEPTH  = nnfs_pkg::STORE_DEPTH_DEF,
  parameter int MAX_DEST_DIM = nnfs_pkg::MAX_DEST_DIM_DEF,
  parameter int PIXEL_BITS   = nnfs_pkg::PIXEL_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [nnfs_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [nnfs_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_mode,
  input  logic [nnfs_pkg::IN_PIX_BITS-1:0]    in_pixel,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [nnfs_pkg::IN_PIX_BITS-1:0]    out_pixel,
  output logic [nnfs_pkg::OFFSET_BITS-1:0]    out_dest_offset,
  output logic                                out_frame_last
);

  import nnfs_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);

  // Configuration registers
  logic [SRC_W_BITS-1:0] sw_r;
  logic [SRC_H_BITS-1:0] sh_r;
  logic [DIM_BITS-1:0]   dw_r;
  logic [DIM_BITS-1:0]   dh_r;
  logic [DIM_BITS-1:0]   pitch_r;
  logic                  cfg_wr;

  // Setup sequencer
  state_t                  state_r, state_nxt;
  logic                    div_start;
  logic                    div_done_x, div_done_y;
  logic [SRC_W_BITS-1:0]   qx, qy;
  logic [DIM_BITS-1:0]     rx, ry;
  logic [FS_BITS-1:0]      fs_full;
  logic [FS_BITS-1:0]      fs_r;
  logic [2*SRC_W_BITS-1:0] ystep_full;
  logic [AW-1:0]           ystep_r;
  logic                    en_r, en_nxt;
  logic [AW:0]             lim_r, lim_nxt;

  // Load and emit counters
  logic [AW-1:0]          ptr_r, ptr_nxt;
  logic [AW:0]            ptr_p1;
  logic [DIM_BITS-1:0]    col_r, col_nxt;
  logic [DIM_BITS-1:0]    row_r, row_nxt;
  logic [SRC_W_BITS-1:0]  sx_r, sx_nxt;
  logic [DIM_BITS-1:0]    rx_r, rx_nxt;
  logic [DIM_BITS-1:0]    ry_r, ry_nxt;
  logic [AW-1:0]          row_base_r, row_base_nxt;
  logic [OFFSET_BITS-1:0] off_base_r, off_base_nxt;
  logic [DIM_BITS:0]      col_p1, row_p1;
  logic                   col_wrap, row_wrap;
  logic [DIM_BITS:0]      rx_sum, ry_sum;
  logic                   rx_ge, ry_ge;
  logic [DIM_BITS:0]      rx_fix, ry_fix;

  // Handshake and datapath
  logic                   in_acc, load_acc, emit_go;
  logic [AW-1:0]          rd_idx;
  logic [OFFSET_BITS-1:0] cur_off;
  logic                   cur_last;
  logic [PIXEL_BITS+IN_PIX_BITS-1:0] wr_wide;
  logic [PIXEL_BITS-1:0]  ram_wdata;
  logic [PIXEL_BITS-1:0]  ram_rdata;
  logic [PIXEL_BITS+IN_PIX_BITS-1:0] rd_wide;

  // Read in flight and output register
  logic                   p_r;
  logic [OFFSET_BITS-1:0] p_off_r;
  logic                   p_last_r;
  logic                   p_move;
  logic                   o_r;
  logic [IN_PIX_BITS-1:0] o_pix_r;
  logic [OFFSET_BITS-1:0] o_off_r;
  logic                   o_last_r;

  // ---------------------------------------------------------------------------
  // Configuration: always ready; an index beyond the list is dropped silently
  // and leaves the counters alone.
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready && (cfg_index < CFG_IDX_BITS'(NUM_CFG));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r    <= SRC_W_RST;
      sh_r    <= SRC_H_RST;
      dw_r    <= DST_W_RST;
      dh_r    <= DST_H_RST;
      pitch_r <= PITCH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SRC_WIDTH:  sw_r    <= cfg_data[SRC_W_BITS-1:0];
        CFG_SRC_HEIGHT: sh_r    <= cfg_data[SRC_H_BITS-1:0];
        CFG_DST_WIDTH:  dw_r    <= cfg_data[DIM_BITS-1:0];
        CFG_DST_HEIGHT: dh_r    <= cfg_data[DIM_BITS-1:0];
        CFG_ROW_PITCH:  pitch_r <= cfg_data[DIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Setup: frame size, then column/row steps (quotient and remainder of the
  // source over destination dimension), then the source index step per row.
  // The incremental walk then needs one add and compare per axis per word.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_START: state_nxt = ST_DIV;
      ST_DIV:   if (div_done_x && div_done_y) state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_RUN;
      ST_RUN:   state_nxt = ST_RUN;
      default:  state_nxt = ST_START;
    endcase
    // a register write restarts the setup from scratch
    if (cfg_wr) begin
      state_nxt = ST_START;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_START;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign div_start = (state_r == ST_START);

  nnfs_div #(
    .N_BITS(SRC_W_BITS),
    .D_BITS(DIM_BITS)
  ) u_nnfs_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sw_r),
    .divisor  (dw_r),
    .quotient (qx),
    .remainder(rx),
    .done     (div_done_x)
  );

  nnfs_div #(
    .N_BITS(SRC_W_BITS),
    .D_BITS(DIM_BITS)
  ) u_nnfs_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({{(SRC_W_BITS-SRC_H_BITS){1'b0}}, sh_r}),
    .divisor  (dh_r),
    .quotient (qy),
    .remainder(ry),
    .done     (div_done_y)
  );

  assign fs_full    = sw_r * sh_r;
  assign ystep_full = qy * sw_r;

  always_comb begin
    en_nxt = (sw_r != '0) && (sh_r != '0) && (dw_r != '0) && (dh_r != '0) &&
             (pitch_r >= dw_r) &&
             (32'(dw_r) <= 32'(MAX_DEST_DIM)) && (32'(dh_r) <= 32'(MAX_DEST_DIM)) &&
             (32'(fs_r) <= 32'(STORE_DEPTH));
    // loads wrap at the frame size, or at the store depth if that is unusable
    if ((fs_r == '0) || (32'(fs_r) > 32'(STORE_DEPTH))) begin
      lim_nxt = (AW+1)'(STORE_DEPTH);
    end else begin
      lim_nxt = (AW+1)'(fs_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= 1'b0;
    end else begin
      if (state_r == ST_START) begin
        fs_r <= fs_full;
        en_r <= 1'b0;
      end
      if (state_r == ST_MUL) begin
        ystep_r <= AW'(ystep_full);
        en_r    <= en_nxt;
        lim_r   <= lim_nxt;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: stall during setup, and while a finished read cannot advance.
  // ---------------------------------------------------------------------------
  assign p_move   = p_r && (!o_r || !out_stall);
  assign in_stall = (state_r != ST_RUN) || (p_r && o_r && out_stall);
  assign in_acc   = in_valid && !in_stall;
  assign load_acc = in_acc && !in_mode;
  assign emit_go  = in_acc && in_mode && en_r;

  // ---------------------------------------------------------------------------
  // Address generation
  // ---------------------------------------------------------------------------
  always_comb begin
    ptr_p1  = {1'b0, ptr_r} + (AW+1)'(1);
    ptr_nxt = (ptr_p1 >= lim_r) ? '0 : ptr_p1[AW-1:0];

    rd_idx   = row_base_r + AW'(sx_r);
    cur_off  = off_base_r + OFFSET_BITS'(col_r);
    col_p1   = {1'b0, col_r} + (DIM_BITS+1)'(1);
    row_p1   = {1'b0, row_r} + (DIM_BITS+1)'(1);
    col_wrap = col_p1 >= {1'b0, dw_r};
    row_wrap = row_p1 >= {1'b0, dh_r};
    cur_last = (col_p1 == {1'b0, dw_r}) && (row_p1 == {1'b0, dh_r});

    rx_sum = {1'b0, rx_r} + {1'b0, rx};
    rx_ge  = rx_sum >= {1'b0, dw_r};
    rx_fix = rx_ge ? rx_sum - {1'b0, dw_r} : rx_sum;
    ry_sum = {1'b0, ry_r} + {1'b0, ry};
    ry_ge  = ry_sum >= {1'b0, dh_r};
    ry_fix = ry_ge ? ry_sum - {1'b0, dh_r} : ry_sum;

    col_nxt      = col_r;
    row_nxt      = row_r;
    sx_nxt       = sx_r;
    rx_nxt       = rx_r;
    ry_nxt       = ry_r;
    row_base_nxt = row_base_r;
    off_base_nxt = off_base_r;

    if (!col_wrap) begin
      // advance one destination column
      col_nxt = col_p1[DIM_BITS-1:0];
      sx_nxt  = sx_r + qx + SRC_W_BITS'(rx_ge);
      rx_nxt  = rx_fix[DIM_BITS-1:0];
    end else begin
      col_nxt = '0;
      sx_nxt  = '0;
      rx_nxt  = '0;
      if (row_wrap) begin
        row_nxt      = '0;
        ry_nxt       = '0;
        row_base_nxt = '0;
        off_base_nxt = '0;
      end else begin
        // advance one destination row
        row_nxt      = row_p1[DIM_BITS-1:0];
        ry_nxt       = ry_fix[DIM_BITS-1:0];
        row_base_nxt = row_base_r + ystep_r + (ry_ge ? AW'(sw_r) : AW'(0));
        off_base_nxt = off_base_r + OFFSET_BITS'(pitch_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr) begin
      ptr_r      <= '0;
      col_r      <= '0;
      row_r      <= '0;
      sx_r       <= '0;
      rx_r       <= '0;
      ry_r       <= '0;
      row_base_r <= '0;
      off_base_r <= '0;
    end else begin
      if (load_acc) begin
        ptr_r <= ptr_nxt;
      end
      if (emit_go) begin
        col_r      <= col_nxt;
        row_r      <= row_nxt;
        sx_r       <= sx_nxt;
        rx_r       <= rx_nxt;
        ry_r       <= ry_nxt;
        row_base_r <= row_base_nxt;
        off_base_r <= off_base_nxt;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Frame store: loads write, emits read. One port of each, never both used
  // by one word, so a read always sees every earlier load.
  // ---------------------------------------------------------------------------
  assign wr_wide   = {{PIXEL_BITS{1'b0}}, in_pixel};
  assign ram_wdata = wr_wide[PIXEL_BITS-1:0];

  nnfs_ram #(
    .WIDTH(PIXEL_BITS),
    .DEPTH(STORE_DEPTH)
  ) u_nnfs_ram (
    .clk  (clk),
    .we   (load_acc),
    .waddr(ptr_r),
    .wdata(ram_wdata),
    .re   (emit_go),
    .raddr(rd_idx),
    .rdata(ram_rdata)
  );

  assign rd_wide = {{IN_PIX_BITS{1'b0}}, ram_rdata};

  // ---------------------------------------------------------------------------
  // Read in flight, then output register. The RAM holds its read data while
  // the in-flight word waits for the output register to free up.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r <= 1'b0;
      o_r <= 1'b0;
    end else begin
      if (emit_go) begin
        p_r <= 1'b1;
      end else if (p_move) begin
        p_r <= 1'b0;
      end
      if (p_move) begin
        o_r <= 1'b1;
      end else if (!out_stall) begin
        o_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      p_off_r  <= cur_off;
      p_last_r <= cur_last;
    end
    if (p_move) begin
      o_pix_r  <= rd_wide[IN_PIX_BITS-1:0];
      o_off_r  <= p_off_r;
      o_last_r <= p_last_r;
    end
  end

  assign out_valid       = o_r;
  assign out_pixel       = o_pix_r;
  assign out_dest_offset = o_off_r;
  assign out_frame_last  = o_last_r;

endmodule

### hdl/nnfs_checker.sv
// Port-level checker for the scaler, bound to the top level.
`include "nearest_neighbor_frame_scaler_defines.svh"

module nnfs_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                cfg_valid,
  input logic                                cfg_ready,
  input logic [nnfs_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [nnfs_pkg::IN_PIX_BITS-1:0]    out_pixel,
  input logic [nnfs_pkg::OFFSET_BITS-1:0]    out_dest_offset,
  input logic                                out_frame_last
);

  import nnfs_pkg::*;

  logic cfg_hit;

  assign cfg_hit = cfg_valid && cfg_ready && (cfg_index < CFG_IDX_BITS'(NUM_CFG));

  `NNFS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result word dropped while stalled")
  `NNFS_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_pixel) && $stable(out_dest_offset) && $stable(out_frame_last), "stalled result word changed")
  `NNFS_ASSERT_NEXT_ALWAYS(a_reset_setup, !rst_n, in_stall, "input not stalled for setup after reset")
  `NNFS_ASSERT_NEXT(a_cfg_setup, cfg_hit, in_stall, "input not stalled for setup after register write")

endmodule

bind nearest_neighbor_frame_scaler nnfs_checker u_nnfs_checker (.*);
